@@ rtl/fractal_simplex_noise_3d_unit_assert.svh @@
// Assertion macros shared by the noise unit.
`ifndef FRACTAL_SIMPLEX_NOISE_3D_UNIT_ASSERT_SVH
`define FRACTAL_SIMPLEX_NOISE_3D_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSN3D_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FSN3D_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fsn3d_pkg.sv @@
package fsn3d_pkg;

  localparam int COORD_W    = 32;
  localparam int HEIGHT_W   = 32;
  localparam int PERM_W     = 8;
  localparam int PERM_DEPTH = 256;
  localparam int PERM_AW    = 8;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_GAIN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_LACUNARITY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FREQUENCY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_AMPLITUDE    = 3'd4;

  localparam logic OP_SAMPLE     = 1'b0;
  localparam logic OP_PERM_WRITE = 1'b1;

  localparam int COUNT_W = 5;
  localparam int GAIN_W  = 17;
  localparam int LAC_W   = 19;
  localparam int BASE_W  = 24;

  localparam int DEF_OCTAVE_COUNT      = 4;
  localparam int DEF_OCTAVE_GAIN       = 32768;
  localparam int DEF_OCTAVE_LACUNARITY = 131072;
  localparam int DEF_BASE_FREQUENCY    = 65536;
  localparam int DEF_BASE_AMPLITUDE    = 65536;
  localparam int DEF_OCTAVE_LIMIT      = 16;

  localparam int Q_ONE_THIRD = 21845;
  localparam int Q_ONE_SIXTH = 10923;
  localparam int Q_ATTEN     = 39322;
  localparam int Q_SCALE_MUL = 83886;
  localparam int Q_BIAS      = 8978432;
  localparam int Q_UNIT      = 65536;

  localparam int MUL_W   = 35;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SAT_W   = 56;
  localparam int MAG_W   = 31;
  localparam int S_W     = 34;
  localparam int PS_W    = 36;
  localparam int CELL_W  = 18;
  localparam int CS_W    = 20;
  localparam int T_W     = 36;
  localparam int DD_W    = 38;
  localparam int D_W     = 24;
  localparam int DOT_W   = 26;
  localparam int R2_W    = 50;
  localparam int AF_W    = 36;
  localparam int A_W     = 16;
  localparam int NOISE_W = 22;

  typedef struct packed {
    logic               en;
    logic [PERM_AW-1:0] addr;
    logic [PERM_W-1:0]  data;
  } perm_wr_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MX,
    ST_MY,
    ST_MZ,
    ST_MSUM,
    ST_SKEW,
    ST_CELL,
    ST_TMUL,
    ST_D0,
    ST_ORDER,
    ST_CSET,
    ST_SQX,
    ST_SQY,
    ST_SQZ,
    ST_ATT,
    ST_AMUL,
    ST_A2,
    ST_A4,
    ST_CACC,
    ST_NOISE,
    ST_TOT,
    ST_FRQ,
    ST_AMPU,
    ST_FIN,
    ST_OUT
  } state_t;

  function automatic logic signed [31:0] sat_s32(input logic signed [SAT_W-1:0] v);
    logic signed [31:0] r;
    if (v[SAT_W-1:31] == '0 || v[SAT_W-1:31] == '1) begin
      r = v[31:0];
    end else if (v[SAT_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic logic [MAG_W-1:0] sat_pos31(input logic signed [SAT_W-1:0] v);
    logic [MAG_W-1:0] r;
    if (v[SAT_W-1]) begin
      r = '0;
    end else if (v[SAT_W-2:MAG_W] != '0) begin
      r = '1;
    end else begin
      r = v[MAG_W-1:0];
    end
    return r;
  endfunction

  // Offset of corner n along the main diagonal, n times the unskew factor.
  function automatic logic signed [D_W-1:0] unskew_step(input logic [1:0] n);
    logic signed [D_W-1:0] r;
    case (n)
      2'd0:    r = '0;
      2'd1:    r = D_W'(Q_ONE_SIXTH);
      2'd2:    r = D_W'(2 * Q_ONE_SIXTH);
      2'd3:    r = D_W'(3 * Q_ONE_SIXTH);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/fsn3d_req_if.sv @@
interface fsn3d_req_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  op;
  logic signed [fsn3d_pkg::COORD_W-1:0]  x_coord;
  logic signed [fsn3d_pkg::COORD_W-1:0]  y_coord;
  logic signed [fsn3d_pkg::COORD_W-1:0]  z_coord;
  logic        [fsn3d_pkg::PERM_AW-1:0]  perm_index;
  logic        [fsn3d_pkg::PERM_W-1:0]   perm_value;

  modport source (output valid, op, x_coord, y_coord, z_coord, perm_index, perm_value,
                  input ready);
  modport sink   (input valid, op, x_coord, y_coord, z_coord, perm_index, perm_value,
                  output ready);
endinterface

@@ rtl/fsn3d_res_if.sv @@
interface fsn3d_res_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [fsn3d_pkg::HEIGHT_W-1:0] height;

  modport source (output valid, height, input ready);
  modport sink   (input valid, height, output ready);
endinterface

@@ rtl/fsn3d_perm_ram.sv @@
module fsn3d_perm_ram (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fsn3d_pkg::perm_wr_t                  wr,
  input  logic [fsn3d_pkg::PERM_AW-1:0]        rd_addr,
  output logic [fsn3d_pkg::PERM_W-1:0]         rd_data
);

  // An entry that was never written reads as its own index.
  logic [fsn3d_pkg::PERM_W-1:0]     mem [fsn3d_pkg::PERM_DEPTH];
  logic [fsn3d_pkg::PERM_DEPTH-1:0] written;
  logic [fsn3d_pkg::PERM_W-1:0]     mem_q;
  logic [fsn3d_pkg::PERM_AW-1:0]    addr_q;
  logic                             written_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    mem_q  <= mem[rd_addr];
    addr_q <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      written_q <= written[rd_addr];
    end
  end

  assign rd_data = written_q ? mem_q : fsn3d_pkg::PERM_W'(addr_q);

endmodule

@@ rtl/fractal_simplex_noise_3d_unit.sv @@
// Channel | Dir | Payload                                       | Note
// req     | in  | op, x_coord, y_coord, z_coord, perm_index,    | op 1 writes the table
//         |     | perm_value                                    |
// res     | out | height                                        | one per sample request
// cfg     | in  | cfg_we, cfg_index, cfg_data                   | write only
// A table write request leaves the unit idle. A sample request runs the setup states
// per octave, the corner states per simplex corner, the attenuation states when the
// corner lies inside the attenuation radius, and the update states. The single shared
// multiplier and the three dependent permutation table reads per corner set this order.
// Reset is synchronous; it restores the register defaults and the identity table at once.
// A finished height waits in the output register, and the next request is taken meanwhile;
// a second height waits until the first one has left.
module fractal_simplex_noise_3d_unit #(
  parameter int OCTAVE_LIMIT = fsn3d_pkg::DEF_OCTAVE_LIMIT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [fsn3d_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fsn3d_pkg::CFG_DATA_W-1:0]      cfg_data,
  fsn3d_req_if.sink                             req,
  fsn3d_res_if.source                           res
);

  localparam int OCT_W = $clog2(OCTAVE_LIMIT + 1);

  fsn3d_pkg::state_t state, state_next;

  logic [fsn3d_pkg::COUNT_W-1:0] octave_count;
  logic [fsn3d_pkg::GAIN_W-1:0]  octave_gain;
  logic [fsn3d_pkg::LAC_W-1:0]   octave_lacunarity;
  logic [fsn3d_pkg::BASE_W-1:0]  base_frequency;
  logic [fsn3d_pkg::BASE_W-1:0]  base_amplitude;

  logic signed [fsn3d_pkg::COORD_W-1:0] px, py, pz;
  logic signed [31:0]                   sx, sy, sz;
  logic signed [31:0]                   total;
  logic [fsn3d_pkg::MAG_W-1:0]          freq, amp;
  logic [OCT_W-1:0]                     oct, octaves, octaves_clamp;
  logic signed [fsn3d_pkg::S_W-1:0]     s_reg;
  logic signed [fsn3d_pkg::CELL_W-1:0]  cx, cy, cz;
  logic [15:0]                          fx, fy, fz;
  logic signed [fsn3d_pkg::D_W-1:0]     d0x, d0y, d0z, dx, dy, dz;
  logic [2:0]                           c1, c2, off;
  logic [1:0]                           n;
  logic [2:0]                           grad;
  logic [fsn3d_pkg::R2_W-1:0]           r2, r2_tot;
  logic [fsn3d_pkg::A_W-1:0]            a_reg;
  logic signed [fsn3d_pkg::DOT_W-1:0]   dot, dot_v;
  logic signed [fsn3d_pkg::NOISE_W-1:0] noise;
  logic signed [fsn3d_pkg::AF_W-1:0]    a_full;
  logic                                 corner_last;

  logic signed [fsn3d_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic signed [fsn3d_pkg::PROD_W-1:0]  prod;
  logic signed [fsn3d_pkg::PROD_W-17:0] prod_sh;

  logic signed [fsn3d_pkg::S_W-1:0]     s_v;
  logic signed [fsn3d_pkg::PS_W-1:0]    psx, psy, psz;
  logic signed [fsn3d_pkg::DD_W-1:0]    dfx, dfy, dfz;

  fsn3d_pkg::perm_wr_t                  perm_wr;
  logic [fsn3d_pkg::PERM_AW-1:0]        perm_rd_addr;
  logic [fsn3d_pkg::PERM_W-1:0]         perm_rd_data;

  logic req_fire, res_load;

  fsn3d_perm_ram u_perm_ram (
    .clk     (clk),
    .rst     (rst),
    .wr      (perm_wr),
    .rd_addr (perm_rd_addr),
    .rd_data (perm_rd_data)
  );

  assign req_fire      = req.valid && req.ready;
  assign octaves_clamp = (32'(octave_count) > OCTAVE_LIMIT) ? OCT_W'(OCTAVE_LIMIT)
                                                             : OCT_W'(octave_count);
  assign prod_sh       = $signed(prod[fsn3d_pkg::PROD_W-1:16]);
  assign corner_last   = (n == 2'd3);

  always_comb begin
    case (n)
      2'd0:    off = 3'b000;
      2'd1:    off = c1;
      2'd2:    off = c2;
      default: off = 3'b111;
    endcase
  end

  // Datapath values that feed the registers of the skew and corner steps.
  assign s_v    = $signed(prod[16 + fsn3d_pkg::S_W - 1:16]);
  assign psx    = fsn3d_pkg::PS_W'(sx) + fsn3d_pkg::PS_W'(s_v);
  assign psy    = fsn3d_pkg::PS_W'(sy) + fsn3d_pkg::PS_W'(s_v);
  assign psz    = fsn3d_pkg::PS_W'(sz) + fsn3d_pkg::PS_W'(s_v);
  assign dfx    = fsn3d_pkg::DD_W'($signed({1'b0, fx})) - fsn3d_pkg::DD_W'(s_reg)
                + fsn3d_pkg::DD_W'($signed(prod[fsn3d_pkg::T_W-1:0]));
  assign dfy    = fsn3d_pkg::DD_W'($signed({1'b0, fy})) - fsn3d_pkg::DD_W'(s_reg)
                + fsn3d_pkg::DD_W'($signed(prod[fsn3d_pkg::T_W-1:0]));
  assign dfz    = fsn3d_pkg::DD_W'($signed({1'b0, fz})) - fsn3d_pkg::DD_W'(s_reg)
                + fsn3d_pkg::DD_W'($signed(prod[fsn3d_pkg::T_W-1:0]));
  assign r2_tot = r2 + prod[fsn3d_pkg::R2_W-1:0];
  assign a_full = fsn3d_pkg::AF_W'(fsn3d_pkg::Q_ATTEN)
                - $signed({2'b00, r2_tot[fsn3d_pkg::R2_W-1:16]});
  assign dot_v  = (grad[0] ? -fsn3d_pkg::DOT_W'(dx) : fsn3d_pkg::DOT_W'(dx))
                + (grad[1] ? -fsn3d_pkg::DOT_W'(dy) : fsn3d_pkg::DOT_W'(dy))
                + (grad[2] ? -fsn3d_pkg::DOT_W'(dz) : fsn3d_pkg::DOT_W'(dz));

  always_comb begin
    state_next = state;
    case (state)
      fsn3d_pkg::ST_IDLE: begin
        if (req_fire && req.op == fsn3d_pkg::OP_SAMPLE) begin
          state_next = (octaves_clamp == '0) ? fsn3d_pkg::ST_FIN : fsn3d_pkg::ST_MX;
        end
      end
      fsn3d_pkg::ST_MX:    state_next = fsn3d_pkg::ST_MY;
      fsn3d_pkg::ST_MY:    state_next = fsn3d_pkg::ST_MZ;
      fsn3d_pkg::ST_MZ:    state_next = fsn3d_pkg::ST_MSUM;
      fsn3d_pkg::ST_MSUM:  state_next = fsn3d_pkg::ST_SKEW;
      fsn3d_pkg::ST_SKEW:  state_next = fsn3d_pkg::ST_CELL;
      fsn3d_pkg::ST_CELL:  state_next = fsn3d_pkg::ST_TMUL;
      fsn3d_pkg::ST_TMUL:  state_next = fsn3d_pkg::ST_D0;
      fsn3d_pkg::ST_D0:    state_next = fsn3d_pkg::ST_ORDER;
      fsn3d_pkg::ST_ORDER: state_next = fsn3d_pkg::ST_CSET;
      fsn3d_pkg::ST_CSET:  state_next = fsn3d_pkg::ST_SQX;
      fsn3d_pkg::ST_SQX:   state_next = fsn3d_pkg::ST_SQY;
      fsn3d_pkg::ST_SQY:   state_next = fsn3d_pkg::ST_SQZ;
      fsn3d_pkg::ST_SQZ:   state_next = fsn3d_pkg::ST_ATT;
      fsn3d_pkg::ST_ATT: begin
        if (!a_full[fsn3d_pkg::AF_W-1]) begin
          state_next = fsn3d_pkg::ST_AMUL;
        end else begin
          state_next = corner_last ? fsn3d_pkg::ST_NOISE : fsn3d_pkg::ST_CSET;
        end
      end
      fsn3d_pkg::ST_AMUL:  state_next = fsn3d_pkg::ST_A2;
      fsn3d_pkg::ST_A2:    state_next = fsn3d_pkg::ST_A4;
      fsn3d_pkg::ST_A4:    state_next = fsn3d_pkg::ST_CACC;
      fsn3d_pkg::ST_CACC: begin
        state_next = corner_last ? fsn3d_pkg::ST_NOISE : fsn3d_pkg::ST_CSET;
      end
      fsn3d_pkg::ST_NOISE: state_next = fsn3d_pkg::ST_TOT;
      fsn3d_pkg::ST_TOT:   state_next = fsn3d_pkg::ST_FRQ;
      fsn3d_pkg::ST_FRQ:   state_next = fsn3d_pkg::ST_AMPU;
      fsn3d_pkg::ST_AMPU: begin
        state_next = (oct + 1'b1 == octaves) ? fsn3d_pkg::ST_FIN : fsn3d_pkg::ST_MX;
      end
      fsn3d_pkg::ST_FIN:   state_next = fsn3d_pkg::ST_OUT;
      fsn3d_pkg::ST_OUT: begin
        if (!res.valid || res.ready) begin
          state_next = fsn3d_pkg::ST_IDLE;
        end
      end
      default:             state_next = fsn3d_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready    = (state == fsn3d_pkg::ST_IDLE);
    res_load     = (state == fsn3d_pkg::ST_OUT) && (!res.valid || res.ready);
    perm_wr.en   = req_fire && (req.op == fsn3d_pkg::OP_PERM_WRITE);
    perm_wr.addr = req.perm_index;
    perm_wr.data = req.perm_value;
    perm_rd_addr = '0;
    mul_a        = '0;
    mul_b        = '0;
    case (state)
      fsn3d_pkg::ST_MX: begin
        mul_a = fsn3d_pkg::MUL_W'(px);
        mul_b = fsn3d_pkg::MUL_W'(freq);
      end
      fsn3d_pkg::ST_MY: begin
        mul_a = fsn3d_pkg::MUL_W'(py);
        mul_b = fsn3d_pkg::MUL_W'(freq);
      end
      fsn3d_pkg::ST_MZ: begin
        mul_a = fsn3d_pkg::MUL_W'(pz);
        mul_b = fsn3d_pkg::MUL_W'(freq);
      end
      fsn3d_pkg::ST_SKEW: begin
        mul_a = fsn3d_pkg::MUL_W'(sx) + fsn3d_pkg::MUL_W'(sy) + fsn3d_pkg::MUL_W'(sz);
        mul_b = fsn3d_pkg::MUL_W'(fsn3d_pkg::Q_ONE_THIRD);
      end
      fsn3d_pkg::ST_TMUL: begin
        mul_a = fsn3d_pkg::MUL_W'(fsn3d_pkg::CS_W'(cx) + fsn3d_pkg::CS_W'(cy)
                                  + fsn3d_pkg::CS_W'(cz));
        mul_b = fsn3d_pkg::MUL_W'(fsn3d_pkg::Q_ONE_SIXTH);
      end
      fsn3d_pkg::ST_CSET: begin
        perm_rd_addr = cz[7:0] + {7'd0, off[2]};
      end
      fsn3d_pkg::ST_SQX: begin
        perm_rd_addr = cy[7:0] + {7'd0, off[1]} + perm_rd_data;
        mul_a        = fsn3d_pkg::MUL_W'(dx);
        mul_b        = fsn3d_pkg::MUL_W'(dx);
      end
      fsn3d_pkg::ST_SQY: begin
        perm_rd_addr = cx[7:0] + {7'd0, off[0]} + perm_rd_data;
        mul_a        = fsn3d_pkg::MUL_W'(dy);
        mul_b        = fsn3d_pkg::MUL_W'(dy);
      end
      fsn3d_pkg::ST_SQZ: begin
        mul_a = fsn3d_pkg::MUL_W'(dz);
        mul_b = fsn3d_pkg::MUL_W'(dz);
      end
      fsn3d_pkg::ST_AMUL: begin
        mul_a = fsn3d_pkg::MUL_W'(a_reg);
        mul_b = fsn3d_pkg::MUL_W'(a_reg);
      end
      fsn3d_pkg::ST_A2: begin
        mul_a = fsn3d_pkg::MUL_W'(prod[31:16]);
        mul_b = fsn3d_pkg::MUL_W'(prod[31:16]);
      end
      fsn3d_pkg::ST_A4: begin
        mul_a = fsn3d_pkg::MUL_W'(prod[31:16]);
        mul_b = fsn3d_pkg::MUL_W'(dot);
      end
      fsn3d_pkg::ST_NOISE: begin
        mul_a = fsn3d_pkg::MUL_W'(amp);
        mul_b = fsn3d_pkg::MUL_W'($signed({noise, 5'b00000}));
      end
      fsn3d_pkg::ST_TOT: begin
        mul_a = fsn3d_pkg::MUL_W'(freq);
        mul_b = fsn3d_pkg::MUL_W'(octave_lacunarity);
      end
      fsn3d_pkg::ST_FRQ: begin
        mul_a = fsn3d_pkg::MUL_W'(amp);
        mul_b = fsn3d_pkg::MUL_W'(octave_gain);
      end
      fsn3d_pkg::ST_FIN, fsn3d_pkg::ST_OUT: begin
        mul_a = fsn3d_pkg::MUL_W'(total);
        mul_b = fsn3d_pkg::MUL_W'(fsn3d_pkg::Q_SCALE_MUL);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fsn3d_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count      <= fsn3d_pkg::COUNT_W'(fsn3d_pkg::DEF_OCTAVE_COUNT);
      octave_gain       <= fsn3d_pkg::GAIN_W'(fsn3d_pkg::DEF_OCTAVE_GAIN);
      octave_lacunarity <= fsn3d_pkg::LAC_W'(fsn3d_pkg::DEF_OCTAVE_LACUNARITY);
      base_frequency    <= fsn3d_pkg::BASE_W'(fsn3d_pkg::DEF_BASE_FREQUENCY);
      base_amplitude    <= fsn3d_pkg::BASE_W'(fsn3d_pkg::DEF_BASE_AMPLITUDE);
    end else if (cfg_we) begin
      case (cfg_index)
        fsn3d_pkg::CFG_OCTAVE_COUNT:      octave_count      <= cfg_data[4:0];
        fsn3d_pkg::CFG_OCTAVE_GAIN:       octave_gain       <= cfg_data[16:0];
        fsn3d_pkg::CFG_OCTAVE_LACUNARITY: octave_lacunarity <= cfg_data[18:0];
        fsn3d_pkg::CFG_BASE_FREQUENCY:    base_frequency    <= cfg_data;
        fsn3d_pkg::CFG_BASE_AMPLITUDE:    base_amplitude    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      fsn3d_pkg::ST_IDLE: begin
        px      <= req.x_coord;
        py      <= req.y_coord;
        pz      <= req.z_coord;
        freq    <= fsn3d_pkg::MAG_W'(base_frequency);
        amp     <= fsn3d_pkg::MAG_W'(base_amplitude);
        total   <= '0;
        oct     <= '0;
        octaves <= octaves_clamp;
      end
      fsn3d_pkg::ST_MY:   sx <= fsn3d_pkg::sat_s32(fsn3d_pkg::SAT_W'(prod_sh));
      fsn3d_pkg::ST_MZ:   sy <= fsn3d_pkg::sat_s32(fsn3d_pkg::SAT_W'(prod_sh));
      fsn3d_pkg::ST_MSUM: sz <= fsn3d_pkg::sat_s32(fsn3d_pkg::SAT_W'(prod_sh));
      fsn3d_pkg::ST_CELL: begin
        s_reg <= s_v;
        cx    <= psx[16 + fsn3d_pkg::CELL_W - 1:16];
        cy    <= psy[16 + fsn3d_pkg::CELL_W - 1:16];
        cz    <= psz[16 + fsn3d_pkg::CELL_W - 1:16];
        fx    <= psx[15:0];
        fy    <= psy[15:0];
        fz    <= psz[15:0];
      end
      fsn3d_pkg::ST_D0: begin
        // The skew and unskew terms nearly cancel, so the offsets stay narrow.
        d0x <= dfx[fsn3d_pkg::D_W-1:0];
        d0y <= dfy[fsn3d_pkg::D_W-1:0];
        d0z <= dfz[fsn3d_pkg::D_W-1:0];
      end
      fsn3d_pkg::ST_ORDER: begin
        n     <= 2'd0;
        noise <= '0;
        if (d0x < d0y) begin
          if (d0y < d0z) begin
            c1 <= 3'b100;
            c2 <= 3'b110;
          end else if (d0x < d0z) begin
            c1 <= 3'b010;
            c2 <= 3'b110;
          end else begin
            c1 <= 3'b010;
            c2 <= 3'b011;
          end
        end else begin
          if (d0x < d0z) begin
            c1 <= 3'b100;
            c2 <= 3'b101;
          end else if (d0y < d0z) begin
            c1 <= 3'b001;
            c2 <= 3'b101;
          end else begin
            c1 <= 3'b001;
            c2 <= 3'b011;
          end
        end
      end
      fsn3d_pkg::ST_CSET: begin
        dx <= d0x - (off[0] ? fsn3d_pkg::D_W'(fsn3d_pkg::Q_UNIT) : '0)
              + fsn3d_pkg::unskew_step(n);
        dy <= d0y - (off[1] ? fsn3d_pkg::D_W'(fsn3d_pkg::Q_UNIT) : '0)
              + fsn3d_pkg::unskew_step(n);
        dz <= d0z - (off[2] ? fsn3d_pkg::D_W'(fsn3d_pkg::Q_UNIT) : '0)
              + fsn3d_pkg::unskew_step(n);
      end
      fsn3d_pkg::ST_SQY: r2 <= prod[fsn3d_pkg::R2_W-1:0];
      fsn3d_pkg::ST_SQZ: begin
        r2   <= r2_tot;
        grad <= perm_rd_data[2:0];
      end
      fsn3d_pkg::ST_ATT: begin
        a_reg <= a_full[fsn3d_pkg::A_W-1:0];
        dot   <= dot_v;
        if (a_full[fsn3d_pkg::AF_W-1]) begin
          n <= n + 2'd1;
        end
      end
      fsn3d_pkg::ST_CACC: begin
        noise <= noise + fsn3d_pkg::NOISE_W'(prod_sh);
        n     <= n + 2'd1;
      end
      fsn3d_pkg::ST_TOT: begin
        total <= fsn3d_pkg::sat_s32(fsn3d_pkg::SAT_W'(total) + fsn3d_pkg::SAT_W'(prod_sh));
      end
      fsn3d_pkg::ST_FRQ:  freq <= fsn3d_pkg::sat_pos31(fsn3d_pkg::SAT_W'(prod_sh));
      fsn3d_pkg::ST_AMPU: begin
        amp <= fsn3d_pkg::sat_pos31(fsn3d_pkg::SAT_W'(prod_sh));
        oct <= oct + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (res_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.height <= fsn3d_pkg::sat_s32(fsn3d_pkg::SAT_W'(prod_sh)
                                       + fsn3d_pkg::SAT_W'(fsn3d_pkg::Q_BIAS));
    end
  end

`include "fractal_simplex_noise_3d_unit_assert.svh"

  `FSN3D_ASSERT_NEXT(a_busy_after_sample, clk, rst, req_fire && (req.op == fsn3d_pkg::OP_SAMPLE), !req.ready, "sample request did not close the input")
  `FSN3D_ASSERT_NOW(a_octave_bound, clk, rst, state != fsn3d_pkg::ST_IDLE, oct <= octaves, "octave counter ran past the octave count")
  `FSN3D_ASSERT_NOW(a_atten_range, clk, rst, state == fsn3d_pkg::ST_AMUL, a_reg <= fsn3d_pkg::A_W'(fsn3d_pkg::Q_ATTEN), "attenuation out of range")
  `FSN3D_ASSERT_NOW(a_no_overwrite, clk, rst, res_load, !res.valid || res.ready, "height overwritten before it was taken")

endmodule

@@ tb/noise_checker.sv @@
module noise_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [fsn3d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsn3d_pkg::CFG_DATA_W-1:0] cfg_data,
  fsn3d_req_if                             req,
  fsn3d_res_if                             res,
  output int                               fails,
  output int                               pending
);
  import fsn3d_pkg::*;

  logic [7:0]  perm [256];
  logic [4:0]  cnt_reg;
  logic [16:0] gain_reg;
  logic [18:0] lac_reg;
  logic [23:0] freq_reg;
  logic [23:0] amp_reg;
  logic signed [31:0] heights_due [$];

  assign pending = heights_due.size();

  function automatic longint clamp_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_pos(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < 0) return 0;
    return v;
  endfunction

  function automatic logic [2:0] grad_of(longint a, longint b, longint c);
    logic [7:0] h;
    h = perm[8'(c)];
    h = perm[8'(b + h)];
    h = perm[8'(a + h)];
    return h[2:0];
  endfunction

  function automatic longint corner_term(longint dx, longint dy, longint dz, logic [2:0] g);
    longint att, dot, a2, a4;
    att = Q_ATTEN - ((dx * dx + dy * dy + dz * dz) >>> 16);
    if (att < 0) return 0;
    dot = (g[0] ? -dx : dx) + (g[1] ? -dy : dy) + (g[2] ? -dz : dz);
    a2 = (att * att) >>> 16;
    a4 = (a2 * a2) >>> 16;
    return (a4 * dot) >>> 16;
  endfunction

  function automatic longint simplex_at(longint px, longint py, longint pz);
    longint s, ci, cj, ck, t, dx, dy, dz, acc;
    int o1 [3];
    int o2 [3];
    s = ((px + py + pz) * Q_ONE_THIRD) >>> 16;
    ci = (px + s) >>> 16;
    cj = (py + s) >>> 16;
    ck = (pz + s) >>> 16;
    t = (ci + cj + ck) * Q_ONE_SIXTH;
    dx = px - ci * Q_UNIT + t;
    dy = py - cj * Q_UNIT + t;
    dz = pz - ck * Q_UNIT + t;
    o1 = '{0, 0, 0};
    o2 = '{0, 0, 0};
    if (dx < dy) begin
      if (dy < dz) begin o1[2] = 1; o2[1] = 1; o2[2] = 1; end
      else if (dx < dz) begin o1[1] = 1; o2[1] = 1; o2[2] = 1; end
      else begin o1[1] = 1; o2[0] = 1; o2[1] = 1; end
    end else begin
      if (dx < dz) begin o1[2] = 1; o2[0] = 1; o2[2] = 1; end
      else if (dy < dz) begin o1[0] = 1; o2[0] = 1; o2[2] = 1; end
      else begin o1[0] = 1; o2[0] = 1; o2[1] = 1; end
    end
    acc = corner_term(dx, dy, dz, grad_of(ci, cj, ck));
    acc += corner_term(dx - o1[0] * Q_UNIT + Q_ONE_SIXTH, dy - o1[1] * Q_UNIT + Q_ONE_SIXTH,
                       dz - o1[2] * Q_UNIT + Q_ONE_SIXTH,
                       grad_of(ci + o1[0], cj + o1[1], ck + o1[2]));
    acc += corner_term(dx - o2[0] * Q_UNIT + 2 * Q_ONE_SIXTH,
                       dy - o2[1] * Q_UNIT + 2 * Q_ONE_SIXTH,
                       dz - o2[2] * Q_UNIT + 2 * Q_ONE_SIXTH,
                       grad_of(ci + o2[0], cj + o2[1], ck + o2[2]));
    acc += corner_term(dx - Q_UNIT + 3 * Q_ONE_SIXTH, dy - Q_UNIT + 3 * Q_ONE_SIXTH,
                       dz - Q_UNIT + 3 * Q_ONE_SIXTH, grad_of(ci + 1, cj + 1, ck + 1));
    return acc * 32;
  endfunction

  function automatic logic signed [31:0] fbm_height(longint x, longint y, longint z);
    longint frq, amp, total, nv;
    int octaves;
    frq = freq_reg;
    amp = amp_reg;
    total = 0;
    octaves = (cnt_reg > DEF_OCTAVE_LIMIT) ? DEF_OCTAVE_LIMIT : cnt_reg;
    for (int o = 0; o < octaves; o++) begin
      nv = simplex_at(clamp_s32((x * frq) >>> 16), clamp_s32((y * frq) >>> 16),
                      clamp_s32((z * frq) >>> 16));
      total = clamp_s32(total + ((amp * nv) >>> 16));
      frq = clamp_pos((frq * longint'(lac_reg)) >>> 16);
      amp = clamp_pos((amp * longint'(gain_reg)) >>> 16);
    end
    return 32'(clamp_s32(((total * Q_SCALE_MUL) >>> 16) + Q_BIAS));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 256; i++) perm[i] = 8'(i);
      cnt_reg = 5'(DEF_OCTAVE_COUNT);
      gain_reg = 17'(DEF_OCTAVE_GAIN);
      lac_reg = 19'(DEF_OCTAVE_LACUNARITY);
      freq_reg = 24'(DEF_BASE_FREQUENCY);
      amp_reg = 24'(DEF_BASE_AMPLITUDE);
      heights_due.delete();
      fails = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OCTAVE_COUNT:      cnt_reg = cfg_data[4:0];
          CFG_OCTAVE_GAIN:       gain_reg = cfg_data[16:0];
          CFG_OCTAVE_LACUNARITY: lac_reg = cfg_data[18:0];
          CFG_BASE_FREQUENCY:    freq_reg = cfg_data;
          CFG_BASE_AMPLITUDE:    amp_reg = cfg_data;
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (heights_due.size() == 0) begin
          $display("%0t: unexpected height %0d", $realtime, res.height);
          fails++;
        end else begin
          if (res.height !== heights_due[0]) begin
            $display("%0t: height expected %0d actual %0d", $realtime, heights_due[0],
                     res.height);
            fails++;
          end
          void'(heights_due.pop_front());
        end
      end
      if (req.valid && req.ready) begin
        if (req.op == OP_PERM_WRITE) perm[req.perm_index] = req.perm_value;
        else heights_due.push_back(fbm_height(req.x_coord, req.y_coord, req.z_coord));
      end
    end
  end
endmodule

@@ tb/testbench.sv @@
module testbench;
  import fsn3d_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int fails, pending, idle_cycles;
  bit calm = 0;

  fsn3d_req_if req ();
  fsn3d_res_if res ();

  fractal_simplex_noise_3d_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req.sink), .res(res.source)
  );

  noise_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req), .res(res), .fails(fails), .pending(pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    req.valid = 0;
    req.op = OP_SAMPLE;
    req.x_coord = 0;
    req.y_coord = 0;
    req.z_coord = 0;
    req.perm_index = 0;
    req.perm_value = 0;
    res.ready = 0;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (calm) res.ready <= 1;
    else if ($urandom_range(0, 99) < 3) res.ready <= 0;
    else if (!res.ready && $urandom_range(0, 99) < 85) res.ready <= res.ready;
    else res.ready <= ($urandom_range(0, 99) < 70);
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (res.valid && res.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                      logic [7:0] idx, logic [7:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1;
    req.op <= op;
    req.x_coord <= x;
    req.y_coord <= y;
    req.z_coord <= z;
    req.perm_index <= idx;
    req.perm_value <= val;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic sample(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send(OP_SAMPLE, x, y, z, 8'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    req.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      2: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 9)
                                           : 32'h8000_0000 + $urandom_range(0, 9);
    endcase
  endfunction

  initial begin
    int octs, items;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    sample(0, 0, 0);
    sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    sample(32'hFFFF_0000, 32'h0001_8000, 32'hFFFE_4000);
    sample(32'h0000_8000, 32'hFFFF_FFFF, 32'h0000_0001);
    send(OP_PERM_WRITE, 0, 0, 0, 8'd0, 8'd255);
    send(OP_PERM_WRITE, 0, 0, 0, 8'd255, 8'd7);
    send(OP_PERM_WRITE, 0, 0, 0, 8'd1, 8'd0);
    sample(0, 0, 0);
    sample(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
    drain();
    set_reg(CFG_OCTAVE_COUNT, 24'd0);
    sample(32'h1234_5678, 32'h8765_4321, 32'h0);
    drain();
    set_reg(CFG_OCTAVE_COUNT, 24'd31);
    set_reg(CFG_OCTAVE_GAIN, 24'd131071);
    set_reg(CFG_OCTAVE_LACUNARITY, 24'd524287);
    set_reg(CFG_BASE_FREQUENCY, 24'hFFFFFF);
    set_reg(CFG_BASE_AMPLITUDE, 24'hFFFFFF);
    set_reg(3'd7, 24'h5A5A5A);
    sample(32'h0003_1000, 32'hFFFC_2000, 32'h0000_7000);
    sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    drain();
    set_reg(CFG_OCTAVE_COUNT, 24'd16);
    set_reg(CFG_OCTAVE_GAIN, 24'd0);
    set_reg(CFG_OCTAVE_LACUNARITY, 24'd0);
    set_reg(CFG_BASE_FREQUENCY, 24'd0);
    set_reg(CFG_BASE_AMPLITUDE, 24'd0);
    sample(32'h0005_0000, 32'h0002_0000, 32'hFFF0_0000);
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      calm = (phase % 4 == 3);
      case ($urandom_range(0, 9))
        0: octs = 0;
        1: octs = $urandom_range(16, 31);
        default: octs = $urandom_range(1, 5);
      endcase
      set_reg(CFG_OCTAVE_COUNT, 24'(octs));
      set_reg(CFG_OCTAVE_GAIN, 24'($urandom_range(0, 3) == 0 ? $urandom_range(0, 131071)
                                                              : $urandom_range(16384, 65536)));
      set_reg(CFG_OCTAVE_LACUNARITY,
              24'($urandom_range(0, 3) == 0 ? $urandom_range(0, 524287)
                                            : $urandom_range(65536, 196608)));
      set_reg(CFG_BASE_FREQUENCY, 24'($urandom_range(0, 3) == 0 ? $urandom_range(0, 24'hFFFFFF)
                                                                 : $urandom_range(4096, 262144)));
      set_reg(CFG_BASE_AMPLITUDE, 24'($urandom_range(0, 3) == 0 ? $urandom_range(0, 24'hFFFFFF)
                                                                 : $urandom_range(4096, 262144)));
      items = (octs > 5) ? 25 : 95;
      for (int n = 0; n < items; n++) begin
        if ($urandom_range(0, 99) < 20) send(OP_PERM_WRITE, $urandom, $urandom, $urandom,
                                             8'($urandom), 8'($urandom));
        else sample(rand_coord(), rand_coord(), rand_coord());
        if (n == items / 2 && phase == 5) drain();
      end
      drain();
    end
    calm = 0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
